// ===== src/isotp_pkg.sv =====
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types and constants for the response segmenter: protocol modes,
// configuration register indexes, item and frame payload structures.
// ----------------------------------------------------------------------------
package isotp_pkg;

    // Largest number of data bytes in one frame
    localparam int MAX_FRAME_DATA = 7;
    // Data bytes carried by a first frame
    localparam int FF_DATA = 6;

    // Fixed header bytes
    localparam logic [7:0] HDR_CAN11_BYTE = 8'h07;
    localparam logic [7:0] HDR_CAN29_BYTE = 8'hDA;
    localparam logic [7:0] HDR_KLINE_BYTE = 8'h41;

    // PCI frame type nibbles
    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    // Header and PCI byte counts
    localparam logic [2:0] HLEN_CAN11 = 3'd2;
    localparam logic [2:0] HLEN_CAN29 = 3'd4;
    localparam logic [2:0] HLEN_NONCAN = 3'd3;
    localparam logic [1:0] PLEN_NONE  = 2'd0;
    localparam logic [1:0] PLEN_ONE   = 2'd1;
    localparam logic [1:0] PLEN_TWO   = 2'd2;

    typedef enum logic [1:0] {
        MODE_CAN11 = 2'd0,
        MODE_CAN29 = 2'd1,
        MODE_KLINE = 2'd2,
        MODE_OTHER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_PROTOCOL_MODE  = 2'd0,
        CFG_TESTER_ADDRESS = 2'd1,
        CFG_CAN_PRIORITY   = 2'd2,
        CFG_ADD_CHECKSUM   = 2'd3
    } cfg_idx_t;

    // Configuration register set
    typedef struct packed {
        mode_t      protocol_mode;
        logic [7:0] tester_address;
        logic [7:0] can_priority;
        logic       add_checksum;
    } cfg_t;

    // One request item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] message_length;
        logic [7:0]  ecu_address;
    } item_t;

    // One outgoing frame
    typedef struct packed {
        logic [31:0] header_bytes;
        logic [2:0]  header_length;
        logic [15:0] pci_bytes;
        logic [1:0]  pci_length;
        logic [55:0] payload;
        logic [2:0]  payload_length;
        logic [7:0]  checksum;
        logic        checksum_valid;
        logic        last_frame;
    } frame_t;

endpackage

// ===== src/isotp_if.sv =====
// ----------------------------------------------------------------------------
// isotp channel interfaces
// Valid/ready channels for message bytes, outgoing frames and register writes.
// ----------------------------------------------------------------------------
interface isotp_req_if import isotp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [11:0] message_length;
    logic [7:0]  ecu_address;

    modport source (output valid, data_byte, message_length, ecu_address, input ready);
    modport sink   (input valid, data_byte, message_length, ecu_address, output ready);
endinterface

interface isotp_frm_if import isotp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] header_bytes;
    logic [2:0]  header_length;
    logic [15:0] pci_bytes;
    logic [1:0]  pci_length;
    logic [55:0] payload;
    logic [2:0]  payload_length;
    logic [7:0]  checksum;
    logic        checksum_valid;
    logic        last_frame;

    modport source (output valid, header_bytes, header_length, pci_bytes, pci_length,
                    payload, payload_length, checksum, checksum_valid, last_frame,
                    input ready);
    modport sink   (input valid, header_bytes, header_length, pci_bytes, pci_length,
                    payload, payload_length, checksum, checksum_valid, last_frame,
                    output ready);
endinterface

interface isotp_cfg_if import isotp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/isotp_cfg.sv =====
// ----------------------------------------------------------------------------
// isotp_cfg
// Configuration register file; takes one register write per cycle.
// ----------------------------------------------------------------------------
module isotp_cfg import isotp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    isotp_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the write index
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_PROTOCOL_MODE:  regs_next.protocol_mode  = mode_t'(cfg.data[1:0]);
                CFG_TESTER_ADDRESS: regs_next.tester_address = cfg.data;
                CFG_CAN_PRIORITY:   regs_next.can_priority   = cfg.data;
                CFG_ADD_CHECKSUM:   regs_next.add_checksum   = cfg.data[0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.protocol_mode  <= MODE_CAN11;
            regs_reg.tester_address <= 8'd241;
            regs_reg.can_priority   <= 8'd24;
            regs_reg.add_checksum   <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== src/isotp_framer.sv =====
// ----------------------------------------------------------------------------
// isotp_framer
// Message state and frame building: collects bytes into a chunk and forms
// header, PCI, payload and checksum when the chunk fills or the message ends.
// ----------------------------------------------------------------------------
module isotp_framer import isotp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   regs,
    input  item_t  item,
    input  logic   step,
    output logic   emit,
    output frame_t frame
);

    logic [11:0] bytes_taken_reg, bytes_taken_next;
    logic [11:0] latched_length_reg, latched_length_next;
    logic [7:0]  latched_address_reg, latched_address_next;
    logic [3:0]  sequence_reg, sequence_next;
    logic [55:0] chunk_reg, chunk_next;
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  chunk_sum_reg, chunk_sum_next;
    logic        multi_reg, multi_next;
    logic        first_reg, first_next;

    logic        start;
    logic [11:0] len_in;
    logic [11:0] eff_len;
    logic [7:0]  eff_addr;
    logic        eff_multi;
    logic        eff_first;
    logic [3:0]  eff_seq;
    logic [2:0]  eff_fill;
    logic [55:0] eff_chunk;
    logic [7:0]  eff_sum;
    logic [55:0] chunk_n;
    logic [2:0]  fill_n;
    logic [7:0]  sum_n;
    logic [11:0] taken_n;
    logic        is_can;
    logic [2:0]  cap;
    logic        last;

    // Pick up length and address on the first byte of a message
    always_comb
    begin
        start     = (bytes_taken_reg == '0);
        len_in    = (item.message_length == '0) ? 12'd1 : item.message_length;
        eff_len   = start ? len_in : latched_length_reg;
        eff_addr  = start ? item.ecu_address : latched_address_reg;
        eff_multi = start ? (len_in > 12'(MAX_FRAME_DATA)) : multi_reg;
        eff_first = start ? 1'b1 : first_reg;
        eff_seq   = start ? 4'd0 : sequence_reg;
        eff_fill  = start ? 3'd0 : fill_reg;
        eff_chunk = start ? 56'd0 : chunk_reg;
        eff_sum   = start ? 8'd0 : chunk_sum_reg;
    end

    // Shift the byte in and decide whether the frame is complete
    always_comb
    begin
        chunk_n = {eff_chunk[47:0], item.data_byte};
        fill_n  = eff_fill + 3'd1;
        sum_n   = eff_sum + item.data_byte;
        taken_n = bytes_taken_reg + 12'd1;
        is_can  = (regs.protocol_mode == MODE_CAN11) || (regs.protocol_mode == MODE_CAN29);
        cap     = (is_can && eff_multi && eff_first) ? 3'(FF_DATA) : 3'(MAX_FRAME_DATA);
        last    = (taken_n >= eff_len);
        emit    = last || (fill_n >= cap);
    end

    // Build header, PCI and checksum
    always_comb
    begin
        frame = '0;
        case (regs.protocol_mode)
            MODE_CAN11:
            begin
                frame.header_bytes  = {16'd0, HDR_CAN11_BYTE, eff_addr};
                frame.header_length = HLEN_CAN11;
            end
            MODE_CAN29:
            begin
                frame.header_bytes  = {regs.can_priority, HDR_CAN29_BYTE,
                                       regs.tester_address, eff_addr};
                frame.header_length = HLEN_CAN29;
            end
            default:
            begin
                frame.header_bytes  = {8'd0, HDR_KLINE_BYTE, regs.tester_address, eff_addr};
                frame.header_length = HLEN_NONCAN;
            end
        endcase

        if (!is_can)
        begin
            frame.pci_bytes  = 16'd0;
            frame.pci_length = PLEN_NONE;
        end
        else if (eff_multi && eff_first)
        begin
            frame.pci_bytes  = {PCI_FIRST, eff_len};
            frame.pci_length = PLEN_TWO;
        end
        else if (eff_multi)
        begin
            frame.pci_bytes  = {8'd0, PCI_CONSECUTIVE, eff_seq};
            frame.pci_length = PLEN_ONE;
        end
        else
        begin
            frame.pci_bytes  = {8'd0, PCI_SINGLE, 1'b0, fill_n};
            frame.pci_length = PLEN_ONE;
        end

        frame.payload        = chunk_n;
        frame.payload_length = fill_n;
        frame.last_frame     = last;

        if ((regs.protocol_mode == MODE_KLINE) && regs.add_checksum)
        begin
            frame.checksum       = HDR_KLINE_BYTE + regs.tester_address + eff_addr + sum_n;
            frame.checksum_valid = 1'b1;
        end
    end

    // Advance the message state on each consumed byte
    always_comb
    begin
        bytes_taken_next     = bytes_taken_reg;
        latched_length_next  = latched_length_reg;
        latched_address_next = latched_address_reg;
        sequence_next        = sequence_reg;
        chunk_next           = chunk_reg;
        fill_next            = fill_reg;
        chunk_sum_next       = chunk_sum_reg;
        multi_next           = multi_reg;
        first_next           = first_reg;
        if (step)
        begin
            latched_length_next  = eff_len;
            latched_address_next = eff_addr;
            multi_next           = eff_multi;
            if (last)
            begin
                bytes_taken_next = 12'd0;
                first_next       = 1'b1;
                sequence_next    = 4'd0;
                chunk_next       = 56'd0;
                fill_next        = 3'd0;
                chunk_sum_next   = 8'd0;
            end
            else if (emit)
            begin
                bytes_taken_next = taken_n;
                first_next       = 1'b0;
                sequence_next    = eff_seq + 4'd1;
                chunk_next       = 56'd0;
                fill_next        = 3'd0;
                chunk_sum_next   = 8'd0;
            end
            else
            begin
                bytes_taken_next = taken_n;
                first_next       = eff_first;
                sequence_next    = eff_seq;
                chunk_next       = chunk_n;
                fill_next        = fill_n;
                chunk_sum_next   = sum_n;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg <= '0;
            sequence_reg    <= '0;
            fill_reg        <= '0;
            multi_reg       <= 1'b0;
            first_reg       <= 1'b1;
        end
        else
        begin
            bytes_taken_reg <= bytes_taken_next;
            sequence_reg    <= sequence_next;
            fill_reg        <= fill_next;
            multi_reg       <= multi_next;
            first_reg       <= first_next;
        end
    end

    // Hold the chunk and latched message fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_length_reg  <= '0;
            latched_address_reg <= '0;
            chunk_reg           <= '0;
            chunk_sum_reg       <= '0;
        end
        else
        begin
            latched_length_reg  <= latched_length_next;
            latched_address_reg <= latched_address_next;
            chunk_reg           <= chunk_next;
            chunk_sum_reg       <= chunk_sum_next;
        end
    end

endmodule

// ===== src/isotp_response_segmenter.sv =====
// Path: the request carrying a frame's last byte is held in the input register,
//   then its frame is loaded into the frame register that drives the channel.
// Throughput: one request per cycle; a full frame register that is not being read
//   stalls requests that complete a frame. The frame register decouples the sides.
// Reset: rst_n clears the valid flags of both pipeline registers and the message
//   state, and loads the configuration defaults (CAN 11-bit, tester 0xF1, priority 0x18).
// ----------------------------------------------------------------------------
// isotp_response_segmenter
// Cuts a byte stream of response messages into CAN or K-line frames.
// ----------------------------------------------------------------------------
module isotp_response_segmenter import isotp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    isotp_req_if.sink    req,
    isotp_frm_if.source  frm,
    isotp_cfg_if.sink    cfg
);

    cfg_t   regs;
    logic   req_valid_reg, req_valid_next;
    item_t  req_item_reg;
    logic   frm_valid_reg, frm_valid_next;
    frame_t frm_data_reg;
    logic   out_free;
    logic   consume;
    logic   emit;
    frame_t frame;

    isotp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    isotp_framer u_framer (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .item  (req_item_reg),
        .step  (consume),
        .emit  (emit),
        .frame (frame)
    );

    // Consume the held request when it completes no frame or its frame has a place to go
    assign out_free  = !frm_valid_reg || frm.ready;
    assign consume   = req_valid_reg && (!emit || out_free);
    assign req.ready = !req_valid_reg || consume;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req.ready)
        begin
            req_valid_next = req.valid;
        end
        frm_valid_next = frm_valid_reg;
        if (consume && emit)
        begin
            frm_valid_next = 1'b1;
        end
        else if (frm.ready)
        begin
            frm_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    // Load request and frame payloads
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_item_reg <= '{data_byte:      req.data_byte,
                              message_length: req.message_length,
                              ecu_address:    req.ecu_address};
        end
        if (consume && emit)
        begin
            frm_data_reg <= frame;
        end
    end

    // Drive the frame channel
    assign frm.valid          = frm_valid_reg;
    assign frm.header_bytes   = frm_data_reg.header_bytes;
    assign frm.header_length  = frm_data_reg.header_length;
    assign frm.pci_bytes      = frm_data_reg.pci_bytes;
    assign frm.pci_length     = frm_data_reg.pci_length;
    assign frm.payload        = frm_data_reg.payload;
    assign frm.payload_length = frm_data_reg.payload_length;
    assign frm.checksum       = frm_data_reg.checksum;
    assign frm.checksum_valid = frm_data_reg.checksum_valid;
    assign frm.last_frame     = frm_data_reg.last_frame;

endmodule

// ===== test/isotp_response_segmenter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isotp_response_segmenter_tb
// Feeds response bytes through the segmenter and checks every frame it emits
// against its directed row or a cycle-free model of the ISO-TP cutting rules. A
// short table of directed requests comes first. Random phases follow, one per
// register setting. The phases run with random gaps on both channels, one long
// receiver hold-off and one gap-free stretch. Each phase boundary drains the block.
// ----------------------------------------------------------------------------
module isotp_response_segmenter_tb;
    import isotp_pkg::*;

    typedef struct {
        item_t  it;
        bit     known;
        frame_t f;
    } stim_row_t;

    typedef struct {
        bit     known;
        frame_t f;
    } frame_tag_t;

    logic clk;
    logic rst_n;

    isotp_req_if req_ch ();
    isotp_frm_if frm_ch ();
    isotp_cfg_if cfg_ch ();

    isotp_response_segmenter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .frm   (frm_ch),
        .cfg   (cfg_ch)
    );

    // Scoreboard storage
    frame_t     frames_due[$];
    frame_tag_t row_tags[$];
    stim_row_t  dir_rows[$];
    int         errors = 0;

    // Shared traffic controls
    bit no_gaps      = 1'b0;
    bit hold_request = 1'b0;
    int msg_left     = 0;

    // Register copy and segmentation state of the model
    cfg_t        cur_cfg = '{MODE_CAN11, 8'd241, 8'd24, 1'b0};
    logic [11:0] seg_taken = '0;
    logic [11:0] seg_len   = '0;
    logic [7:0]  seg_addr  = '0;
    logic [3:0]  seg_seq   = '0;
    logic [55:0] seg_chunk = '0;
    logic [2:0]  seg_fill  = '0;
    bit          seg_multi = 1'b0;
    bit          seg_first = 1'b1;

    // Sum the low n bytes of a value
    function automatic logic [7:0] byte_sum(logic [63:0] v, int n);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < n; i++) s = s + v[8*i +: 8];
        return s;
    endfunction

    // Take one message byte; return 1 with the frame it completes
    function automatic bit segment_byte(input item_t it, output frame_t f);
        bit is_can;
        int cap;
        bit last;
        f = '0;
        is_can = (cur_cfg.protocol_mode == MODE_CAN11) ||
                 (cur_cfg.protocol_mode == MODE_CAN29);
        // Latch length and address on the first byte of a message
        if (seg_taken == 0) begin
            seg_len   = (it.message_length == 0) ? 12'd1 : it.message_length;
            seg_addr  = it.ecu_address;
            seg_multi = (seg_len > MAX_FRAME_DATA);
            seg_first = 1'b1;
            seg_seq   = '0;
            seg_fill  = '0;
            seg_chunk = '0;
        end
        seg_chunk = {seg_chunk[47:0], it.data_byte};
        seg_fill  = seg_fill + 3'd1;
        seg_taken = seg_taken + 12'd1;
        cap  = (is_can && seg_multi && seg_first) ? FF_DATA : MAX_FRAME_DATA;
        last = (seg_taken >= seg_len);
        if (!last && seg_fill < cap) return 1'b0;

        // Build the header for the current mode
        case (cur_cfg.protocol_mode)
            MODE_CAN11: begin
                f.header_bytes  = {16'h0, HDR_CAN11_BYTE, seg_addr};
                f.header_length = HLEN_CAN11;
            end
            MODE_CAN29: begin
                f.header_bytes  = {cur_cfg.can_priority, HDR_CAN29_BYTE,
                                   cur_cfg.tester_address, seg_addr};
                f.header_length = HLEN_CAN29;
            end
            default: begin
                f.header_bytes  = {8'h0, HDR_KLINE_BYTE, cur_cfg.tester_address, seg_addr};
                f.header_length = HLEN_NONCAN;
            end
        endcase

        // Pick the PCI: first, consecutive or single frame; none off CAN
        if (!is_can) begin
            f.pci_bytes  = '0;
            f.pci_length = PLEN_NONE;
        end else if (seg_multi && seg_first) begin
            f.pci_bytes  = {PCI_FIRST, seg_len};
            f.pci_length = PLEN_TWO;
        end else if (seg_multi) begin
            f.pci_bytes  = {8'h0, PCI_CONSECUTIVE, seg_seq};
            f.pci_length = PLEN_ONE;
        end else begin
            f.pci_bytes  = {8'h0, PCI_SINGLE, 1'b0, seg_fill};
            f.pci_length = PLEN_ONE;
        end

        f.payload        = seg_chunk;
        f.payload_length = seg_fill;
        if (cur_cfg.protocol_mode == MODE_KLINE && cur_cfg.add_checksum) begin
            f.checksum = byte_sum(64'(f.header_bytes), int'(f.header_length)) +
                         byte_sum(64'(f.pci_bytes), int'(f.pci_length)) +
                         byte_sum(64'(seg_chunk), int'(seg_fill));
            f.checksum_valid = 1'b1;
        end
        f.last_frame = last;

        // Advance to the next chunk; rewind at message end
        seg_seq   = seg_seq + 4'd1;
        seg_first = 1'b0;
        seg_chunk = '0;
        seg_fill  = '0;
        if (last) begin
            seg_taken = '0;
            seg_first = 1'b1;
            seg_seq   = '0;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // Frame with no checksum, for the directed rows
    function automatic frame_t mk_frame(logic [31:0] h, logic [2:0] hl, logic [15:0] p,
                                        logic [1:0] pl, logic [55:0] d, logic [2:0] dl,
                                        bit last);
        frame_t f;
        f = '0;
        f.header_bytes   = h;
        f.header_length  = hl;
        f.pci_bytes      = p;
        f.pci_length     = pl;
        f.payload        = d;
        f.payload_length = dl;
        f.last_frame     = last;
        return f;
    endfunction

    function automatic void add_row(logic [7:0] b, logic [11:0] len, logic [7:0] addr,
                                    bit known, frame_t f);
        stim_row_t r;
        r.it.data_byte      = b;
        r.it.message_length = len;
        r.it.ecu_address    = addr;
        r.known = known;
        r.f     = f;
        dir_rows.push_back(r);
    endfunction

    // Next byte of a random message stream; force_len sets the next message length
    function automatic item_t next_msg_byte(int force_len);
        item_t it;
        int    n;
        int    r;
        it.data_byte      = 8'($urandom);
        it.message_length = 12'($urandom);
        it.ecu_address    = 8'($urandom);
        if (msg_left == 0) begin
            r = $urandom_range(0, 19);
            if (force_len >= 0) n = force_len;
            else if (r == 0)    n = 0;
            else if (r <= 6)    n = $urandom_range(1, 7);
            else if (r <= 11)   n = $urandom_range(8, 14);
            else if (r <= 16)   n = $urandom_range(15, 40);
            else if (r <= 18)   n = $urandom_range(41, 130);
            else                n = $urandom_range(131, 260);
            it.message_length = 12'(n);
            msg_left = (n == 0) ? 1 : n;
        end
        msg_left--;
        return it;
    endfunction

    // Offer one request, with random gaps ahead of it
    task automatic send(item_t it, bit known, frame_t f);
        frame_tag_t tag;
        while (!no_gaps && $urandom_range(0, 99) < 28) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tag.known = known;
        tag.f     = f;
        row_tags.push_back(tag);
        req_ch.valid          <= 1'b1;
        req_ch.data_byte      <= it.data_byte;
        req_ch.message_length <= it.message_length;
        req_ch.ecu_address    <= it.ecu_address;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Hold the sender until every frame is back and the pipeline is empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write all four registers; unused upper data bits carry noise
    task automatic write_cfg(mode_t mode, logic [7:0] tester, logic [7:0] prio, bit cks);
        logic [5:0] pad;
        logic [6:0] pad_ck;
        pad    = 6'($urandom);
        pad_ck = 7'($urandom);
        write_reg(CFG_PROTOCOL_MODE, {pad, mode});
        write_reg(CFG_TESTER_ADDRESS, tester);
        write_reg(CFG_CAN_PRIORITY, prio);
        write_reg(CFG_ADD_CHECKSUM, {pad_ck, cks});
        cfg_ch.valid <= 1'b0;
    endtask

    // Clock and reset
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Frame receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        frm_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                frm_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 300;
                frm_ch.ready <= 1'b0;
            end else begin
                frm_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // Monitor: track register writes, predict on accepted requests, check frames
    always @(posedge clk) begin : monitor
        item_t      it;
        frame_t     f;
        frame_t     want;
        frame_tag_t tag;
        bit         made;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_PROTOCOL_MODE:  cur_cfg.protocol_mode  = mode_t'(cfg_ch.data[1:0]);
                    CFG_TESTER_ADDRESS: cur_cfg.tester_address = cfg_ch.data;
                    CFG_CAN_PRIORITY:   cur_cfg.can_priority   = cfg_ch.data;
                    CFG_ADD_CHECKSUM:   cur_cfg.add_checksum   = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                it.data_byte      = req_ch.data_byte;
                it.message_length = req_ch.message_length;
                it.ecu_address    = req_ch.ecu_address;
                tag  = row_tags.pop_front();
                made = segment_byte(it, f);
                if (tag.known) frames_due.push_back(tag.f);
                else if (made) frames_due.push_back(f);
            end
            if (frm_ch.valid && frm_ch.ready) begin
                if (frames_due.size() == 0) begin
                    $error("frame with no request pending: header %0h payload %0h",
                           frm_ch.header_bytes, frm_ch.payload);
                    errors++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("header_bytes", 64'(want.header_bytes),
                                64'(frm_ch.header_bytes));
                    check_field("header_length", 64'(want.header_length),
                                64'(frm_ch.header_length));
                    check_field("pci_bytes", 64'(want.pci_bytes), 64'(frm_ch.pci_bytes));
                    check_field("pci_length", 64'(want.pci_length), 64'(frm_ch.pci_length));
                    check_field("payload", 64'(want.payload), 64'(frm_ch.payload));
                    check_field("payload_length", 64'(want.payload_length),
                                64'(frm_ch.payload_length));
                    check_field("checksum", 64'(want.checksum), 64'(frm_ch.checksum));
                    check_field("checksum_valid", 64'(want.checksum_valid),
                                64'(frm_ch.checksum_valid));
                    check_field("last_frame", 64'(want.last_frame), 64'(frm_ch.last_frame));
                end
            end
        end
    end

    // Stimulus
    initial begin
        int ph;
        int n;
        req_ch.valid          = 1'b0;
        req_ch.data_byte      = '0;
        req_ch.message_length = '0;
        req_ch.ecu_address    = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;

        // Directed rows, CAN 11-bit defaults after reset
        add_row(8'hFF, 12'd1, 8'h00, 1'b1,
                mk_frame(32'h0700, HLEN_CAN11, 16'h0001, PLEN_ONE, 56'hFF, 3'd1, 1'b1));
        // zero length counts as one byte
        add_row(8'h00, 12'd0, 8'hFF, 1'b1,
                mk_frame(32'h07FF, HLEN_CAN11, 16'h0001, PLEN_ONE, 56'h00, 3'd1, 1'b1));
        // full single frame
        add_row(8'h01, 12'd7, 8'h10, 1'b0, '0);
        for (int i = 2; i <= 6; i++) add_row(i[7:0], 12'hFFF, 8'hFF, 1'b0, '0);
        add_row(8'h07, 12'h000, 8'h00, 1'b1,
                mk_frame(32'h0710, HLEN_CAN11, 16'h0007, PLEN_ONE, 56'h01020304050607,
                         3'd7, 1'b1));
        // shortest first frame plus consecutive frame
        add_row(8'hA0, 12'd8, 8'h7E, 1'b0, '0);
        for (int i = 1; i <= 4; i++) add_row(8'hA0 + i[7:0], 12'hFFF, 8'h00, 1'b0, '0);
        add_row(8'hA5, 12'h000, 8'hFF, 1'b1,
                mk_frame(32'h077E, HLEN_CAN11, 16'h1008, PLEN_TWO, 56'hA0A1A2A3A4A5,
                         3'd6, 1'b0));
        add_row(8'hA6, 12'hFFF, 8'hFF, 1'b0, '0);
        add_row(8'hA7, 12'h000, 8'h00, 1'b1,
                mk_frame(32'h077E, HLEN_CAN11, 16'h0021, PLEN_ONE, 56'hA6A7, 3'd2, 1'b1));
        add_row(8'h00, 12'd2, 8'h5A, 1'b0, '0);
        add_row(8'hFF, 12'hFFF, 8'hA5, 1'b1,
                mk_frame(32'h075A, HLEN_CAN11, 16'h0002, PLEN_ONE, 56'h00FF, 3'd2, 1'b1));

        @(posedge rst_n);
        @(posedge clk);
        foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].known, dir_rows[i].f);

        // Random phases; a phase may end in the middle of a message
        for (ph = 1; ph <= 8; ph++) begin
            settle();
            case (ph)
                1: write_cfg(MODE_CAN29, 8'h00, 8'hFF, 1'b1);
                2: write_cfg(MODE_KLINE, 8'hFF, 8'h00, 1'b1);
                3: write_cfg(MODE_OTHER, 8'($urandom), 8'($urandom), 1'b1);
                4: write_cfg(MODE_KLINE, 8'($urandom), 8'($urandom), 1'b0);
                5: write_cfg(MODE_CAN11, 8'($urandom), 8'($urandom), 1'($urandom));
                8: write_cfg(MODE_CAN29, 8'($urandom), 8'($urandom), 1'($urandom));
                default: write_cfg(mode_t'($urandom_range(0, 3)), 8'($urandom),
                                   8'($urandom), 1'($urandom));
            endcase
            no_gaps = (ph == 5);
            for (n = 0; n < 150; n++) begin
                if (ph == 2 && n == 20) hold_request = 1'b1;
                send(next_msg_byte(-1), 1'b0, '0);
            end
        end

        // Finish the open message, then part of a longest one
        while (msg_left != 0) send(next_msg_byte(-1), 1'b0, '0);
        for (n = 0; n < 200; n++) send(next_msg_byte(4095), 1'b0, '0);

        settle();
        if (frames_due.size() != 0) begin
            $error("%0d frames never arrived", frames_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/isotp_pkg.sv
src/isotp_if.sv
src/isotp_cfg.sv
src/isotp_framer.sv
src/isotp_response_segmenter.sv
test/isotp_response_segmenter_tb.sv
